/* hdl/ddo_pkg.sv */
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and constants for the odometry block
// payload structs, register indexes, cordic angle table
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int CFG_W = 24;
    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_RIGHT_GAIN = 3'd0;
    localparam logic [IDX_W-1:0] REG_LEFT_GAIN  = 3'd1;
    localparam logic [IDX_W-1:0] REG_DIST_TICK  = 3'd2;
    localparam logic [IDX_W-1:0] REG_ANGLE_TICK = 3'd3;
    localparam logic [IDX_W-1:0] REG_SAMPLE_RATE = 3'd4;

    localparam logic signed [47:0] POS48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] NEG48 = 48'sh8000_0000_0000;
    localparam logic signed [33:0] CORDIC_START = 34'sh0_26DD_3B6A;

    typedef struct packed {
        logic               command;
        logic [15:0]        left_count;
        logic [15:0]        right_count;
        logic signed [39:0] new_x;
        logic signed [39:0] new_y;
        logic [31:0]        new_heading;
    } in_item_t;

    typedef struct packed {
        logic signed [39:0] pos_x;
        logic signed [39:0] pos_y;
        logic [31:0]        heading;
        logic signed [47:0] total_distance;
        logic signed [47:0] total_rotation;
        logic signed [47:0] linear_velocity;
        logic signed [47:0] angular_velocity;
    } out_item_t;

    // multiplier request/response between sequencer and shared unit
    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic [4:0]         shift;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic signed [47:0] result;
    } mul_rsp_t;

    function automatic logic [31:0] atan_lookup(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
                5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA;  5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30;  5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C;  5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3;  5'd23: r = 32'h00000051;
                5'd24: r = 32'h00000029;  5'd25: r = 32'h00000014;
                5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
                5'd28: r = 32'h00000003;  5'd29: r = 32'h00000001;
                5'd30: r = 32'h00000001;  default: r = 32'h00000000;
            endcase
            return r;
        end
    endfunction

endpackage

/* hdl/ddo_mul.sv */
// ----------------------------------------------------------------------------
// ddo_mul: shared multi-cycle multiply, floor shift and 48-bit saturation
// magnitudes are multiplied 16 bits of b per cycle into a 128-bit sum
// ----------------------------------------------------------------------------
module ddo_mul
(
    input  logic              clk,
    input  logic              rst_n,
    input  ddo_pkg::mul_req_t req,
    output ddo_pkg::mul_rsp_t rsp
);
    import ddo_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_RUN  = 3'b010,
        M_FIN  = 3'b100
    } mstate_t;

    mstate_t            state_reg, state_next;
    logic [63:0]        ua_reg, ua_next;
    logic [63:0]        ub_reg, ub_next;
    logic               neg_reg, neg_next;
    logic [4:0]         sh_reg, sh_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic [127:0]       acc_reg, acc_next;
    logic signed [47:0] res_reg, res_next;
    logic               done_reg, done_next;

    logic [79:0]  part;
    logic [127:0] biased;
    logic [127:0] shifted;
    logic [47:0]  lim;

    always_comb
    begin
        part    = ua_reg * ub_reg[15:0];
        biased  = acc_reg + (neg_reg ? ((128'd1 << sh_reg) - 128'd1) : 128'd0);
        shifted = biased >> sh_reg;
        lim     = neg_reg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    end

    always_comb
    begin
        state_next = state_reg;
        ua_next    = ua_reg;
        ub_next    = ub_reg;
        neg_next   = neg_reg;
        sh_next    = sh_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            M_IDLE:
            begin
                if (req.start)
                begin
                    ua_next    = req.a[63] ? 64'(-req.a) : req.a;
                    ub_next    = req.b[63] ? 64'(-req.b) : req.b;
                    neg_next   = req.a[63] ^ req.b[63];
                    sh_next    = req.shift;
                    cnt_next   = 2'd0;
                    acc_next   = '0;
                    state_next = M_RUN;
                end
            end
            M_RUN:
            begin
                acc_next = acc_reg + ({48'd0, part} << {cnt_reg, 4'd0});
                ub_next  = ub_reg >> 16;
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = M_FIN;
                end
            end
            M_FIN:
            begin
                if (shifted > {80'd0, lim})
                begin
                    res_next = neg_reg ? NEG48 : POS48;
                end
                else
                begin
                    res_next = neg_reg ? 48'(-shifted[47:0]) : shifted[47:0];
                end
                done_next  = 1'b1;
                state_next = M_IDLE;
            end
            default: state_next = M_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ua_reg  <= ua_next;
        ub_reg  <= ub_next;
        neg_reg <= neg_next;
        sh_reg  <= sh_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

/* hdl/ddo_cordic.sv */
// ----------------------------------------------------------------------------
// ddo_cordic: iterative rotation cordic giving cos and sin in q2.30
// one micro-rotation per cycle after nearest-quadrant reduction
// ----------------------------------------------------------------------------
module ddo_cordic #(
    parameter int ITERS = 24
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        angle,
    output logic               done,
    output logic signed [33:0] cos_out,
    output logic signed [33:0] sin_out
);
    import ddo_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [4:0]         it_reg, it_next;
    logic [1:0]         q_reg, q_next;
    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic [1:0]         q_in;
    logic [31:0]        z_in;
    logic signed [33:0] xs, ys, at;

    always_comb
    begin
        q_in = 2'((angle + 32'h2000_0000) >> 30);
        z_in = angle - {q_in, 30'd0};
        xs   = x_reg >>> it_reg;
        ys   = y_reg >>> it_reg;
        at   = 34'(atan_lookup(it_reg));
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        it_next   = it_reg;
        q_next    = q_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                it_next   = '0;
                q_next    = q_in;
                x_next    = CORDIC_START;
                y_next    = '0;
                z_next    = 34'(signed'(z_in));
            end
        end
        else
        begin
            if (z_reg >= 0)
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            it_next = it_reg + 5'd1;
            if (32'(it_reg) == ITERS - 1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg <= it_next;
        q_reg  <= q_next;
        x_reg  <= x_next;
        y_reg  <= y_next;
        z_reg  <= z_next;
    end

    always_comb
    begin
        case (q_reg)
            2'd0:    begin cos_out = x_reg;  sin_out = y_reg;  end
            2'd1:    begin cos_out = -y_reg; sin_out = x_reg;  end
            2'd2:    begin cos_out = -x_reg; sin_out = -y_reg; end
            default: begin cos_out = y_reg;  sin_out = -x_reg; end
        endcase
    end

    assign done = done_reg;

endmodule

/* hdl/differential_drive_odometry.sv */
// ----------------------------------------------------------------------------
// differential_drive_odometry: midpoint differential-drive pose tracker
// a sequencer drives one shared multiplier and an iterative cordic
// ----------------------------------------------------------------------------
// a sample item runs eight multiplies, each a launch state and a wait for the result,
//   and a cordic run at the midpoint heading between the rotation and dx multiplies;
//   a set-pose item loads the pose and goes straight to the output state
// one item at a time: the next item is accepted only once the result has been taken
// reset: pose, previous counts, totals and velocities clear; registers take
//   their documented defaults
module differential_drive_odometry #(
    parameter int COUNTER_BITS    = 16,
    parameter int TRIG_ITERATIONS = 24
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [ddo_pkg::IDX_W-1:0]  cfg_index,
    input  logic [ddo_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  ddo_pkg::in_item_t          in_item,
    output logic                       out_valid,
    input  logic                       out_ready,
    output ddo_pkg::out_item_t         out_item
);
    import ddo_pkg::*;

    // sequencer states: each multiply gets its own launch state and returns through the shared wait state
    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_GAIN_L = 13'b0000000000010,
        S_GAIN_R = 13'b0000000000100,
        S_DT     = 13'b0000000001000,
        S_DR     = 13'b0000000010000,
        S_TRIG   = 13'b0000000100000,
        S_DX     = 13'b0000001000000,
        S_DY     = 13'b0000010000000,
        S_LV     = 13'b0000100000000,
        S_AV     = 13'b0001000000000,
        S_WAIT   = 13'b0010000000000,
        S_CWAIT  = 13'b0100000000000,
        S_OUT    = 13'b1000000000000
    } state_t;

    // configuration registers
    logic [15:0] right_gain_reg, left_gain_reg, sample_rate_reg;
    logic [23:0] dist_tick_reg, angle_tick_reg;

    // architectural state
    logic [COUNTER_BITS-1:0] prev_left_reg, prev_right_reg;
    logic signed [39:0]      x_reg, y_reg;
    logic [31:0]             heading_reg;
    logic signed [47:0]      dist_acc_reg, rot_acc_reg, lin_vel_reg, ang_vel_reg;

    // working registers
    state_t             state_reg, ret_reg;
    in_item_t           item_reg;
    logic signed [47:0] gl_reg, gr_reg, dt_reg, dr_reg, dx_reg;
    logic signed [33:0] cos_reg, sin_reg;
    logic               out_valid_reg;

    logic     [COUNTER_BITS-1:0] lc, rc;
    logic signed [COUNTER_BITS-1:0] dl, dr;
    mul_req_t mreq;
    mul_rsp_t mrsp;
    logic     trig_start, trig_done;
    logic signed [33:0] cos_w, sin_w;
    logic signed [48:0] dsum, rsum;
    logic [31:0] mid;

    ddo_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

    ddo_cordic #(.ITERS(TRIG_ITERATIONS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(trig_start), .angle(mid),
        .done(trig_done), .cos_out(cos_w), .sin_out(sin_w)
    );

    // wrapped counter deltas
    assign lc  = COUNTER_BITS'(item_reg.left_count);
    assign rc  = COUNTER_BITS'(item_reg.right_count);
    assign dl  = signed'(lc - prev_left_reg);
    assign dr  = signed'(rc - prev_right_reg);
    assign mid = heading_reg + 32'(dr_reg >>> 1);
    assign trig_start = (state_reg == S_TRIG);

    // multiplier operand select per state
    always_comb
    begin
        mreq.start = 1'b0;
        mreq.a     = '0;
        mreq.b     = '0;
        mreq.shift = '0;
        case (state_reg)
            S_GAIN_L: begin mreq.start = 1'b1; mreq.a = 64'(dl);
                            mreq.b = 64'(left_gain_reg); end
            S_GAIN_R: begin mreq.start = 1'b1; mreq.a = 64'(dr);
                            mreq.b = 64'(right_gain_reg); end
            S_DT:     begin mreq.start = 1'b1; mreq.a = 64'(gr_reg + gl_reg);
                            mreq.b = 64'(dist_tick_reg); mreq.shift = 5'd22; end
            S_DR:     begin mreq.start = 1'b1; mreq.a = 64'(gr_reg - gl_reg);
                            mreq.b = 64'(angle_tick_reg); mreq.shift = 5'd14; end
            S_DX:     begin mreq.start = 1'b1; mreq.a = 64'(dt_reg);
                            mreq.b = 64'(cos_reg); mreq.shift = 5'd30; end
            S_DY:     begin mreq.start = 1'b1; mreq.a = 64'(dt_reg);
                            mreq.b = 64'(sin_reg); mreq.shift = 5'd30; end
            S_LV:     begin mreq.start = 1'b1; mreq.a = 64'(dt_reg);
                            mreq.b = 64'(sample_rate_reg); end
            S_AV:     begin mreq.start = 1'b1; mreq.a = 64'(dr_reg);
                            mreq.b = 64'(sample_rate_reg); end
            default:  mreq.start = 1'b0;
        endcase
    end

    // saturating accumulator sums
    assign dsum = 49'(dist_acc_reg) + 49'(dt_reg);
    assign rsum = 49'(rot_acc_reg) + 49'(dr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            ret_reg         <= S_IDLE;
            out_valid_reg   <= 1'b0;
            right_gain_reg  <= 16'd16384;
            left_gain_reg   <= 16'd16384;
            dist_tick_reg   <= 24'd327680;
            angle_tick_reg  <= 24'd65536;
            sample_rate_reg <= 16'd100;
            prev_left_reg   <= '0;
            prev_right_reg  <= '0;
            x_reg           <= '0;
            y_reg           <= '0;
            heading_reg     <= '0;
            dist_acc_reg    <= '0;
            rot_acc_reg     <= '0;
            lin_vel_reg     <= '0;
            ang_vel_reg     <= '0;
            gl_reg          <= '0;
            gr_reg          <= '0;
            dt_reg          <= '0;
            dr_reg          <= '0;
            dx_reg          <= '0;
            cos_reg         <= '0;
            sin_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_RIGHT_GAIN:  right_gain_reg  <= cfg_data[15:0];
                    REG_LEFT_GAIN:   left_gain_reg   <= cfg_data[15:0];
                    REG_DIST_TICK:   dist_tick_reg   <= cfg_data;
                    REG_ANGLE_TICK:  angle_tick_reg  <= cfg_data;
                    REG_SAMPLE_RATE: sample_rate_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    // accept only once the previous result has drained
                    if (in_valid && !out_valid_reg)
                    begin
                        if (in_item.command)
                        begin
                            x_reg       <= in_item.new_x;
                            y_reg       <= in_item.new_y;
                            heading_reg <= in_item.new_heading;
                            state_reg   <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_GAIN_L;
                        end
                    end
                end
                S_GAIN_L: begin ret_reg <= S_GAIN_R; state_reg <= S_WAIT; end
                S_GAIN_R: begin ret_reg <= S_DT;     state_reg <= S_WAIT; end
                S_DT:     begin ret_reg <= S_DR;     state_reg <= S_WAIT; end
                S_DR:     begin ret_reg <= S_TRIG;   state_reg <= S_WAIT; end
                S_TRIG:   state_reg <= S_CWAIT;
                S_DX:     begin ret_reg <= S_DY;     state_reg <= S_WAIT; end
                S_DY:     begin ret_reg <= S_LV;     state_reg <= S_WAIT; end
                S_LV:     begin ret_reg <= S_AV;     state_reg <= S_WAIT; end
                S_AV:     begin ret_reg <= S_OUT;    state_reg <= S_WAIT; end
                S_WAIT:
                begin
                    // route the multiplier result by which step launched it
                    if (mrsp.done)
                    begin
                        case (ret_reg)
                            S_GAIN_R: gl_reg <= mrsp.result;
                            S_DT:     gr_reg <= mrsp.result;
                            S_DR:     dt_reg <= mrsp.result;
                            S_TRIG:   dr_reg <= mrsp.result;
                            S_DY:     dx_reg <= mrsp.result;
                            S_LV:
                            begin
                                x_reg <= x_reg + 40'(dx_reg);
                                y_reg <= y_reg + 40'(mrsp.result);
                            end
                            S_AV:     lin_vel_reg <= mrsp.result;
                            default:
                            begin
                                // last step of a sample: commit the state
                                ang_vel_reg    <= mrsp.result;
                                heading_reg    <= heading_reg + 32'(dr_reg);
                                prev_left_reg  <= lc;
                                prev_right_reg <= rc;
                                dist_acc_reg   <= (dsum > 49'(POS48)) ? POS48 :
                                                  (dsum < 49'(NEG48)) ? NEG48 :
                                                  dsum[47:0];
                                rot_acc_reg    <= (rsum > 49'(POS48)) ? POS48 :
                                                  (rsum < 49'(NEG48)) ? NEG48 :
                                                  rsum[47:0];
                            end
                        endcase
                        state_reg <= ret_reg;
                    end
                end
                S_CWAIT:
                begin
                    if (trig_done)
                    begin
                        cos_reg   <= cos_w;
                        sin_reg   <= sin_w;
                        state_reg <= S_DX;
                    end
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // input item is captured on accept
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        out_item.pos_x            = x_reg;
        out_item.pos_y            = y_reg;
        out_item.heading          = heading_reg;
        out_item.total_distance   = dist_acc_reg;
        out_item.total_rotation   = rot_acc_reg;
        out_item.linear_velocity  = lin_vel_reg;
        out_item.angular_velocity = ang_vel_reg;
    end

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for differential_drive_odometry
// walks a directed table of encoder samples and set-pose items, then random
// items over several register settings and idling modes; every result is
// compared field by field to a typed row or the fixed-point pose predictor
// ----------------------------------------------------------------------------
module tb_top;
    import ddo_pkg::*;

    // idling modes
    localparam int MODE_NONE = 0;
    localparam int MODE_SEND = 1;
    localparam int MODE_RECV = 2;
    localparam int MODE_BOTH = 3;

    localparam int SETTLE_CYCLES = 100;  // a bit over the sample latency
    localparam int RAND_PER_PHASE = 175;

    localparam logic signed [127:0] WIDE_POS48 = 128'sh7FFF_FFFF_FFFF;
    localparam logic signed [127:0] WIDE_NEG48 = -128'sh8000_0000_0000;

    // arctangent steps in 2^-32 turn, first 24 entries
    localparam logic [31:0] ATAN_STEP [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_item;

    differential_drive_odometry uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always #5 clk = ~clk;

    // predictor copy of registers and pose state
    logic [15:0] gain_r, gain_l, rate;
    logic [23:0] dist_tick, ang_tick;
    logic [15:0] last_l, last_r;
    logic [39:0] px, py;
    logic [31:0] hd;
    longint      dist_sum, rot_sum, lin_vel, ang_vel;

    out_item_t pose_q[$];
    int        errors = 0;
    int        stall_pct = 0;
    int        idle_pct = 0;

    // floor(a*b / 2^s), clamped to 48-bit signed
    function automatic longint mul_floor_sat(input longint a, input longint b, input int s);
        logic signed [127:0] wa, wb, p;
        begin
            wa = a;
            wb = b;
            p = (wa * wb) >>> s;
            if (p > WIDE_POS48) p = WIDE_POS48;
            if (p < WIDE_NEG48) p = WIDE_NEG48;
            return longint'(p);
        end
    endfunction

    function automatic longint clamp48(input longint v);
        begin
            if (v > longint'(WIDE_POS48)) return longint'(WIDE_POS48);
            if (v < longint'(WIDE_NEG48)) return longint'(WIDE_NEG48);
            return v;
        end
    endfunction

    // quadrant fold then rotation-mode cordic, Q2.30 out
    task automatic cordic_cos_sin(input logic [31:0] ang, output longint c, output longint s);
        logic [31:0] sum;
        logic [1:0]  q;
        logic [31:0] rem;
        longint      x, y, z, nx;
        begin
            sum = ang + 32'h2000_0000;
            q = sum[31:30];
            rem = ang - {q, 30'b0};
            z = longint'(signed'(rem));
            x = longint'(CORDIC_START);
            y = 0;
            for (int i = 0; i < 24; i++)
            begin
                if (z >= 0)
                begin
                    nx = x - (y >>> i);
                    y = y + (x >>> i);
                    z = z - longint'(ATAN_STEP[i]);
                end
                else
                begin
                    nx = x + (y >>> i);
                    y = y - (x >>> i);
                    z = z + longint'(ATAN_STEP[i]);
                end
                x = nx;
            end
            case (q)
                2'd0: begin c = x;  s = y;  end
                2'd1: begin c = -y; s = x;  end
                2'd2: begin c = -x; s = -y; end
                default: begin c = y; s = -x; end
            endcase
        end
    endtask

    // advance the predicted pose by one item and return the new state
    task automatic predict_pose(input in_item_t it, output out_item_t r);
        logic signed [15:0] d16;
        longint dl, dr, gl, gr, step_d, step_r, c, s;
        logic [31:0] mid;
        begin
            if (it.command)
            begin
                px = it.new_x;
                py = it.new_y;
                hd = it.new_heading;
            end
            else
            begin
                d16 = it.left_count - last_l;
                dl = d16;
                d16 = it.right_count - last_r;
                dr = d16;
                gl = dl * longint'(gain_l);
                gr = dr * longint'(gain_r);
                step_d = mul_floor_sat(gr + gl, longint'(dist_tick), 22);
                step_r = mul_floor_sat(gr - gl, longint'(ang_tick), 14);
                mid = hd + 32'(step_r >>> 1);
                last_l = it.left_count;
                last_r = it.right_count;
                cordic_cos_sin(mid, c, s);
                px = px + 40'(mul_floor_sat(step_d, c, 30));
                py = py + 40'(mul_floor_sat(step_d, s, 30));
                hd = hd + 32'(step_r);
                dist_sum = clamp48(dist_sum + step_d);
                rot_sum = clamp48(rot_sum + step_r);
                lin_vel = mul_floor_sat(step_d, longint'(rate), 0);
                ang_vel = mul_floor_sat(step_r, longint'(rate), 0);
            end
            r.pos_x = px;
            r.pos_y = py;
            r.heading = hd;
            r.total_distance = 48'(dist_sum);
            r.total_rotation = 48'(rot_sum);
            r.linear_velocity = 48'(lin_vel);
            r.angular_velocity = 48'(ang_vel);
        end
    endtask

    task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= val;
            @(posedge clk);
            cfg_we <= 1'b0;
            case (idx)
                REG_RIGHT_GAIN:  gain_r = val[15:0];
                REG_LEFT_GAIN:   gain_l = val[15:0];
                REG_DIST_TICK:   dist_tick = val;
                REG_ANGLE_TICK:  ang_tick = val;
                REG_SAMPLE_RATE: rate = val[15:0];
                default: ;
            endcase
        end
    endtask

    // block goes idle: all results back, then let any tail work finish
    task automatic drain();
        begin
            while (pose_q.size() != 0) @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    // drive one item; a typed expectation overrides the predicted one
    task automatic send_item(input in_item_t it, input bit known, input out_item_t want);
        out_item_t r;
        begin
            if ($urandom_range(99) < idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while ($urandom_range(99) < idle_pct) @(posedge clk);
            end
            in_item <= it;
            in_valid <= 1'b1;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            predict_pose(it, r);
            pose_q.push_back(known ? want : r);
        end
    endtask

    function automatic in_item_t random_item();
        in_item_t it;
        int sel;
        begin
            it = '0;
            sel = $urandom_range(99);
            it.left_count = last_l + 16'($urandom_range(64) - 32);
            it.right_count = last_r + 16'($urandom_range(64) - 32);
            if (sel < 10)
            begin
                it.command = 1'b1;
                it.new_x = {8'($urandom), 32'($urandom)};
                it.new_y = {8'($urandom), 32'($urandom)};
                it.new_heading = $urandom;
            end
            else if (sel < 30)
            begin
                it.left_count = 16'($urandom);
                it.right_count = 16'($urandom);
            end
            else if (sel < 40)
            begin
                // largest forward or backward count steps
                it.left_count = last_l + ($urandom_range(1) ? 16'h7FFF : 16'h8000);
                it.right_count = last_r + ($urandom_range(1) ? 16'h7FFF : 16'h8000);
            end
            // pose fields are ignored on samples, keep x and heading moving anyway
            if (!it.command)
            begin
                it.new_x = {8'($urandom), 32'($urandom)};
                it.new_heading = $urandom;
            end
            return it;
        end
    endfunction

    // receiver stalls
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    task automatic check_field(input string name, input logic [47:0] want, input logic [47:0] got);
        begin
            if (want !== got)
            begin
                errors++;
                $display("%0t %s expected %h actual %h", $time, name, want, got);
            end
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pose_q.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result, expected none actual %h", $time, out_item);
            end
            else
            begin
                out_item_t w;
                w = pose_q.pop_front();
                check_field("pos_x", 48'(w.pos_x), 48'(out_item.pos_x));
                check_field("pos_y", 48'(w.pos_y), 48'(out_item.pos_y));
                check_field("heading", 48'(w.heading), 48'(out_item.heading));
                check_field("total_distance", w.total_distance, out_item.total_distance);
                check_field("total_rotation", w.total_rotation, out_item.total_rotation);
                check_field("linear_velocity", w.linear_velocity, out_item.linear_velocity);
                check_field("angular_velocity", w.angular_velocity, out_item.angular_velocity);
            end
        end
    end

    typedef struct {
        in_item_t  it;
        bit        known;
        out_item_t want;
    } row_t;

    row_t rows[$];

    function automatic row_t mk(input bit cmd, input logic [15:0] lc, input logic [15:0] rc,
                                input logic [39:0] nx, input logic [39:0] ny,
                                input logic [31:0] nh);
        row_t r;
        begin
            r.it = '{cmd, lc, rc, nx, ny, nh};
            r.known = 1'b0;
            r.want = '0;
            return r;
        end
    endfunction

    initial
    begin
        #30_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        row_t r;
        logic [CFG_W-1:0] rg, lg, dt, at, sr;
        gain_r = 16384; gain_l = 16384; dist_tick = 327680; ang_tick = 65536; rate = 100;
        last_l = 0; last_r = 0; px = 0; py = 0; hd = 0;
        dist_sum = 0; rot_sum = 0; lin_vel = 0; ang_vel = 0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset state, pose extremes, count wrap, largest steps
        r = mk(1'b0, 16'h0000, 16'h0000, 40'h0, 40'h0, 32'h0);
        r.known = 1'b1;  // zero deltas leave everything at zero
        rows.push_back(r);
        r = mk(1'b1, 16'hFFFF, 16'hFFFF, 40'h7F_FFFF_FFFF, 40'h80_0000_0000, 32'hFFFF_FFFF);
        r.known = 1'b1;  // set pose, totals and velocities untouched
        r.want.pos_x = 40'h7F_FFFF_FFFF;
        r.want.pos_y = 40'h80_0000_0000;
        r.want.heading = 32'hFFFF_FFFF;
        rows.push_back(r);
        rows.push_back(mk(1'b0, 16'h0001, 16'h0000, 0, 0, 0));
        rows.push_back(mk(1'b0, 16'h0001, 16'h0001, 0, 0, 0));
        rows.push_back(mk(1'b0, 16'hFFFF, 16'hFFFF, 0, 0, 0));
        rows.push_back(mk(1'b0, 16'h7FFE, 16'h7FFF, 0, 0, 0));
        rows.push_back(mk(1'b0, 16'hFFFE, 16'hFFFF, 0, 0, 0));
        rows.push_back(mk(1'b1, 0, 0, 40'h0, 40'h0, 32'h0));
        rows.push_back(mk(1'b0, 16'h7FFE, 16'h7FFF, 0, 0, 0));
        rows.push_back(mk(1'b0, 16'hFFFE, 16'hFFFF, 0, 0, 0));
        rows.push_back(mk(1'b1, 0, 0, 40'h12_3456_789A, 40'hED_CBA9_8765, 32'h4000_0000));
        rows.push_back(mk(1'b0, 16'h0100, 16'hFF00, 0, 0, 0));
        rows.push_back(mk(1'b1, 0, 0, 40'h0, 40'h0, 32'h8000_0000));
        rows.push_back(mk(1'b0, 16'h0200, 16'h0000, 0, 0, 0));
        rows.push_back(mk(1'b1, 0, 0, 40'h0, 40'h0, 32'hC000_0000));
        rows.push_back(mk(1'b0, 16'h0300, 16'h0100, 0, 0, 0));
        rows.push_back(mk(1'b1, 0, 0, 40'hAA_AAAA_AAAA, 40'h55_5555_5555, 32'hDFFF_FFFF));
        rows.push_back(mk(1'b0, 16'h8300, 16'h8100, 0, 0, 0));
        foreach (rows[i])
            send_item(rows[i].it, rows[i].known, rows[i].want);
        in_valid <= 1'b0;
        drain();

        // random phases, each writing its register settings and picking an idling mode
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin rg = 24'hFFFF; lg = 24'hFFFF; dt = 24'hFF_FFFF; at = 24'hFF_FFFF;
                         sr = 24'hFFFF; end
                1: begin rg = 0; lg = 0; dt = 0; at = 0; sr = 0; end
                2: begin rg = 0; lg = 24'hFFFF; dt = 24'h1; at = 24'hFF_FFFF;
                         sr = 1; end
                default: begin rg = 24'($urandom_range(16'hFFFF));
                               lg = 24'($urandom_range(16'hFFFF));
                               dt = 24'($urandom_range(24'hFF_FFFF));
                               at = 24'($urandom_range(24'hFF_FFFF));
                               sr = 24'($urandom_range(16'hFFFF, 1)); end
            endcase
            cfg_write(REG_RIGHT_GAIN, rg);
            cfg_write(REG_LEFT_GAIN, lg);
            cfg_write(REG_DIST_TICK, dt);
            cfg_write(REG_ANGLE_TICK, at);
            cfg_write(REG_SAMPLE_RATE, sr);
            case (ph % 4)
                MODE_NONE: begin idle_pct = 0;  stall_pct = 0;  end
                MODE_SEND: begin idle_pct = 76; stall_pct = 0;  end
                MODE_RECV: begin idle_pct = 0;  stall_pct = 76; end
                default:   begin idle_pct = 31; stall_pct = 31; end
            endcase
            for (int n = 0; n < RAND_PER_PHASE; n++)
            begin
                // hold off mid-phase until the pipeline is empty
                if (ph == 4 && n == RAND_PER_PHASE / 2)
                begin
                    in_valid <= 1'b0;
                    while (pose_q.size() != 0) @(posedge clk);
                end
                send_item(random_item(), 1'b0, '0);
            end
            in_valid <= 1'b0;
            drain();
        end

        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
